// ----- rtl/core/tbrl_pkg.sv -----
// ----------------------------------------------------------------------------
// tbrl_pkg
// Shared constants and types of the token bucket rate limiter.
// ----------------------------------------------------------------------------
package tbrl_pkg;

    localparam int NUM_BUCKETS = 1024;
    localparam int ID_W        = $clog2(NUM_BUCKETS);
    localparam int FRAC_BITS   = 16;
    localparam int CAP_W       = 16;
    localparam int LVL_W       = CAP_W + FRAC_BITS;
    localparam int TIME_W      = 48;
    localparam int RATE_W      = 32;
    localparam int WAIT_W      = 32;
    localparam int CFG_IDX_W   = 2;

    localparam logic [CAP_W-1:0]     CAP_RESET  = 16'd100;
    localparam logic [RATE_W-1:0]    RATE_RESET = 32'd65536;
    localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_REFILL   = 2'd1;

    typedef struct packed {
        logic              invalid;
        logic              ok;
        logic [CAP_W-1:0]  remaining;
        logic [CAP_W-1:0]  used;
        logic [LVL_W-1:0]  num_full;
        logic [LVL_W-1:0]  num_retry;
    } t_job;

endpackage

// ----- rtl/core/tbrl_front.sv -----
// ----------------------------------------------------------------------------
// tbrl_front
// Request intake: bucket state read-modify-write, refill and grant decision.
// ----------------------------------------------------------------------------
module tbrl_front (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_push,
    output logic                             o_full,
    input  logic [tbrl_pkg::ID_W-1:0]        i_bucket_id,
    input  logic [tbrl_pkg::TIME_W-1:0]      i_now_ms,
    input  logic [tbrl_pkg::CAP_W-1:0]       i_tokens_req,
    input  logic [tbrl_pkg::CAP_W-1:0]       i_capacity,
    input  logic [tbrl_pkg::RATE_W-1:0]      i_rate,
    input  logic                             i_q_full,
    output logic                             o_q_push,
    output tbrl_pkg::t_job                   o_job
);

    localparam int MEM_W = 1 + tbrl_pkg::TIME_W + tbrl_pkg::LVL_W;

    typedef enum logic [4:0] {
        S_CLEAR = 5'b00001,
        S_IDLE  = 5'b00010,
        S_CALC  = 5'b00100,
        S_MUL   = 5'b01000,
        S_FIN   = 5'b10000
    } t_state;

    t_state r_state, n_state;

    logic [MEM_W-1:0] r_mem [0:tbrl_pkg::NUM_BUCKETS-1];
    logic [MEM_W-1:0] r_rd;
    logic [tbrl_pkg::ID_W-1:0] r_clr, n_clr;

    logic [tbrl_pkg::ID_W-1:0]   r_id;
    logic [tbrl_pkg::TIME_W-1:0] r_now;
    logic [tbrl_pkg::CAP_W-1:0]  r_need;
    logic [tbrl_pkg::LVL_W-1:0]  r_lvl;
    logic [tbrl_pkg::LVL_W-1:0]  r_gap;
    logic [tbrl_pkg::TIME_W-1:0] r_time;
    logic [tbrl_pkg::TIME_W-1:0] r_elapsed;
    logic [2*tbrl_pkg::RATE_W-1:0] r_prod;
    logic                        r_big;

    logic                        accept;
    logic                        mem_we;
    logic [tbrl_pkg::ID_W-1:0]   mem_wa;
    logic [MEM_W-1:0]            mem_wd;
    logic [tbrl_pkg::LVL_W-1:0]  cap_fx;
    logic [tbrl_pkg::LVL_W-1:0]  need_fx;
    logic                        rd_use;
    logic [tbrl_pkg::TIME_W-1:0] rd_time;
    logic [tbrl_pkg::LVL_W-1:0]  rd_lvl;
    logic [tbrl_pkg::LVL_W-1:0]  c_lvl;
    logic [tbrl_pkg::TIME_W-1:0] c_time;
    logic [tbrl_pkg::TIME_W-1:0] c_elapsed;
    logic                        to_full;
    logic [tbrl_pkg::LVL_W-1:0]  lvl2;
    logic [tbrl_pkg::LVL_W-1:0]  lvl3;
    logic                        ok;

    assign cap_fx  = {i_capacity, {tbrl_pkg::FRAC_BITS{1'b0}}};
    assign need_fx = {r_need, {tbrl_pkg::FRAC_BITS{1'b0}}};
    assign o_full  = (r_state != S_IDLE) || i_q_full;
    assign accept  = i_push && !o_full;
    assign {rd_use, rd_time, rd_lvl} = r_rd;

    always_comb begin
        if (!rd_use) begin
            c_lvl     = cap_fx;
            c_time    = r_now;
            c_elapsed = '0;
        end else begin
            c_lvl = (rd_lvl > cap_fx) ? cap_fx : rd_lvl;
            if (r_now > rd_time) begin
                c_time    = r_now;
                c_elapsed = r_now - rd_time;
            end else begin
                c_time    = rd_time;
                c_elapsed = '0;
            end
        end
    end

    always_comb begin
        to_full = (i_rate != '0) && (r_big || (r_prod > {{tbrl_pkg::RATE_W{1'b0}}, r_gap}));
        lvl2    = to_full ? cap_fx : (r_lvl + r_prod[tbrl_pkg::LVL_W-1:0]);
        ok      = lvl2 >= need_fx;
        lvl3    = ok ? (lvl2 - need_fx) : lvl2;
    end

    always_comb begin
        o_job.invalid   = 1'b0;
        o_job.ok        = ok;
        o_job.remaining = lvl3[tbrl_pkg::LVL_W-1:tbrl_pkg::FRAC_BITS];
        o_job.used      = i_capacity - lvl3[tbrl_pkg::LVL_W-1:tbrl_pkg::FRAC_BITS];
        o_job.num_full  = cap_fx - lvl3;
        o_job.num_retry = ok ? '0 : (need_fx - lvl3);
        o_q_push        = 1'b0;
        if (r_state == S_IDLE && accept && i_tokens_req == '0) begin
            o_job    = '0;
            o_job.invalid = 1'b1;
            o_q_push = 1'b1;
        end else if (r_state == S_FIN) begin
            o_q_push = 1'b1;
        end
    end

    always_comb begin
        n_state = r_state;
        n_clr   = r_clr;
        mem_we  = 1'b0;
        mem_wa  = r_id;
        mem_wd  = {1'b1, r_time, lvl3};
        case (r_state)
            S_CLEAR: begin
                mem_we = 1'b1;
                mem_wa = r_clr;
                mem_wd = '0;
                n_clr  = r_clr + 1'b1;
                if (r_clr == tbrl_pkg::ID_W'(tbrl_pkg::NUM_BUCKETS - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept && i_tokens_req != '0) begin
                    n_state = S_CALC;
                end
            end
            S_CALC: n_state = S_MUL;
            S_MUL:  n_state = S_FIN;
            S_FIN: begin
                mem_we  = 1'b1;
                n_state = S_IDLE;
            end
            default: n_state = S_CLEAR;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_clr   <= '0;
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa] <= mem_wd;
        end
        r_rd <= r_mem[i_bucket_id];
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_id   <= i_bucket_id;
            r_now  <= i_now_ms;
            r_need <= i_tokens_req;
        end
        if (r_state == S_CALC) begin
            r_lvl     <= c_lvl;
            r_gap     <= cap_fx - c_lvl;
            r_time    <= c_time;
            r_elapsed <= c_elapsed;
        end
        if (r_state == S_MUL) begin
            r_prod <= r_elapsed[tbrl_pkg::RATE_W-1:0] * i_rate;
            r_big  <= |r_elapsed[tbrl_pkg::TIME_W-1:tbrl_pkg::RATE_W];
        end
    end

endmodule

// ----- rtl/core/tbrl_jobq.sv -----
// ----------------------------------------------------------------------------
// tbrl_jobq
// Two-entry queue of decided requests between intake and wait computation.
// ----------------------------------------------------------------------------
module tbrl_jobq (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  tbrl_pkg::t_job i_job,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_empty,
    output tbrl_pkg::t_job o_job
);

    tbrl_pkg::t_job r_buf [0:1];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       do_push, do_pop;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_job   = r_buf[r_rp];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (do_push) r_wp <= ~r_wp;
            if (do_pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, do_push} - {1'b0, do_pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_buf[r_wp] <= i_job;
        end
    end

endmodule

// ----- rtl/core/tbrl_div.sv -----
// ----------------------------------------------------------------------------
// tbrl_div
// Bit-serial ceiling divider, one quotient bit per cycle, saturating on
// a zero divisor.
// ----------------------------------------------------------------------------
module tbrl_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [tbrl_pkg::LVL_W-1:0]    i_num,
    input  logic [tbrl_pkg::RATE_W-1:0]   i_den,
    output logic                          o_done,
    output logic [tbrl_pkg::WAIT_W-1:0]   o_quo
);

    localparam int CNT_W = $clog2(tbrl_pkg::LVL_W);

    logic                         r_busy, r_done;
    logic [CNT_W-1:0]             r_cnt;
    logic [tbrl_pkg::RATE_W-1:0]  r_rem;
    logic [tbrl_pkg::LVL_W-1:0]   r_quo;
    logic [tbrl_pkg::RATE_W-1:0]  r_den;
    logic                         r_num_zero, r_den_zero;
    logic [tbrl_pkg::RATE_W:0]    sh, diff;

    assign sh     = {r_rem, r_quo[tbrl_pkg::LVL_W-1]};
    assign diff   = sh - {1'b0, r_den};
    assign o_done = r_done;

    always_comb begin
        if (r_num_zero)      o_quo = '0;
        else if (r_den_zero) o_quo = '1;
        else                 o_quo = r_quo + tbrl_pkg::WAIT_W'(r_rem != '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_cnt == CNT_W'(tbrl_pkg::LVL_W - 1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_cnt      <= '0;
            r_rem      <= '0;
            r_quo      <= i_num;
            r_den      <= i_den;
            r_num_zero <= (i_num == '0);
            r_den_zero <= (i_den == '0);
        end else if (r_busy) begin
            r_cnt <= r_cnt + 1'b1;
            if (!diff[tbrl_pkg::RATE_W]) begin
                r_rem <= diff[tbrl_pkg::RATE_W-1:0];
                r_quo <= {r_quo[tbrl_pkg::LVL_W-2:0], 1'b1};
            end else begin
                r_rem <= sh[tbrl_pkg::RATE_W-1:0];
                r_quo <= {r_quo[tbrl_pkg::LVL_W-2:0], 1'b0};
            end
        end
    end

endmodule

// ----- rtl/core/tbrl_back.sv -----
// ----------------------------------------------------------------------------
// tbrl_back
// Wait-time computation for decided requests and the result register.
// ----------------------------------------------------------------------------
module tbrl_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_q_empty,
    input  tbrl_pkg::t_job                i_job,
    output logic                          o_q_pop,
    input  logic [tbrl_pkg::RATE_W-1:0]   i_rate,
    input  logic                          i_pop,
    output logic                          o_empty,
    output logic                          o_allowed,
    output logic [tbrl_pkg::CAP_W-1:0]    o_remaining,
    output logic [tbrl_pkg::CAP_W-1:0]    o_used_count,
    output logic [tbrl_pkg::WAIT_W-1:0]   o_reset_after_ms,
    output logic [tbrl_pkg::WAIT_W-1:0]   o_retry_after_ms,
    output logic                          o_request_invalid
);

    typedef enum logic [1:0] {
        B_IDLE = 2'b01,
        B_RUN  = 2'b10
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid;
    tbrl_pkg::t_job r_job;
    logic   start, done_full, done_retry;
    logic [tbrl_pkg::WAIT_W-1:0] q_full, q_retry;

    assign start   = (r_state == B_IDLE) && !i_q_empty && !r_out_valid;
    assign o_q_pop = start;
    assign o_empty = !r_out_valid;

    tbrl_div u_div_full (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_num   (i_job.num_full),
        .i_den   (i_rate),
        .o_done  (done_full),
        .o_quo   (q_full)
    );

    tbrl_div u_div_retry (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_num   (i_job.num_retry),
        .i_den   (i_rate),
        .o_done  (done_retry),
        .o_quo   (q_retry)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            B_IDLE:  if (start) n_state = B_RUN;
            B_RUN:   if (done_full && done_retry) n_state = B_IDLE;
            default: n_state = B_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= B_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == B_RUN && done_full && done_retry) begin
                r_out_valid <= 1'b1;
            end else if (i_pop && r_out_valid) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (start) begin
            r_job <= i_job;
        end
        if (r_state == B_RUN && done_full && done_retry) begin
            o_allowed         <= r_job.ok;
            o_remaining       <= r_job.remaining;
            o_used_count      <= r_job.used;
            o_reset_after_ms  <= q_full;
            o_retry_after_ms  <= q_retry;
            o_request_invalid <= r_job.invalid;
        end
    end

endmodule

// ----- rtl/core/token_bucket_rate_limiter.sv -----
// ----------------------------------------------------------------------------
// token_bucket_rate_limiter
// Per-bucket token bucket admission check with refill and wait times.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake                 Payload
// request   in         push / full               bucket_id, now_ms, tokens_req
// result    out        empty / pop               allowed .. request_invalid
// config    in         cfg_valid / cfg_ready     cfg_index, cfg_data
//
// Intake takes a request through state read, clamp, multiply and write back,
// and accepts no new one before the write back; a zero-token request is queued
// as invalid at once. Wait times come from two bit-serial dividers run side by
// side, started as a job leaves the queue. The result register holds them until
// popped, so no job starts while a result waits. A two-entry queue decouples
// intake from them. After reset, clearing all 1024 buckets holds full high.
// ----------------------------------------------------------------------------
module token_bucket_rate_limiter (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              push,
    output logic                              full,
    input  logic [tbrl_pkg::ID_W-1:0]         i_bucket_id,
    input  logic [tbrl_pkg::TIME_W-1:0]       i_now_ms,
    input  logic [tbrl_pkg::CAP_W-1:0]        i_tokens_req,
    output logic                              empty,
    input  logic                              pop,
    output logic                              o_allowed,
    output logic [tbrl_pkg::CAP_W-1:0]        o_remaining,
    output logic [tbrl_pkg::CAP_W-1:0]        o_used_count,
    output logic [tbrl_pkg::WAIT_W-1:0]       o_reset_after_ms,
    output logic [tbrl_pkg::WAIT_W-1:0]       o_retry_after_ms,
    output logic                              o_request_invalid,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [tbrl_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [tbrl_pkg::RATE_W-1:0]       i_cfg_data
);

    logic [tbrl_pkg::CAP_W-1:0]  r_capacity;
    logic [tbrl_pkg::RATE_W-1:0] r_refill;
    logic           q_push, q_full, q_pop, q_empty;
    tbrl_pkg::t_job f_job, q_job;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity <= tbrl_pkg::CAP_RESET;
            r_refill   <= tbrl_pkg::RATE_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                tbrl_pkg::CFG_CAPACITY: r_capacity <= i_cfg_data[tbrl_pkg::CAP_W-1:0];
                tbrl_pkg::CFG_REFILL:   r_refill   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    tbrl_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_push          (push),
        .o_full          (full),
        .i_bucket_id     (i_bucket_id),
        .i_now_ms        (i_now_ms),
        .i_tokens_req    (i_tokens_req),
        .i_capacity      (r_capacity),
        .i_rate          (r_refill),
        .i_q_full        (q_full),
        .o_q_push        (q_push),
        .o_job           (f_job)
    );

    tbrl_jobq u_jobq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_job   (f_job),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_job   (q_job)
    );

    tbrl_back u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_q_empty         (q_empty),
        .i_job             (q_job),
        .o_q_pop           (q_pop),
        .i_rate            (r_refill),
        .i_pop             (pop),
        .o_empty           (empty),
        .o_allowed         (o_allowed),
        .o_remaining       (o_remaining),
        .o_used_count      (o_used_count),
        .o_reset_after_ms  (o_reset_after_ms),
        .o_retry_after_ms  (o_retry_after_ms),
        .o_request_invalid (o_request_invalid)
    );

    a_no_q_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(q_push && q_full)) else $error("job queue overflow");

    a_no_q_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(q_pop && q_empty)) else $error("job queue underflow");

    a_pop_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pop && !empty) |=> empty) else $error("result reloaded while popped");

    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_request_invalid) |-> (!o_allowed && o_remaining == '0
            && o_retry_after_ms == '0)) else $error("invalid result not zeroed");

endmodule

// ----- tb/sv/token_bucket_rate_limiter_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// token_bucket_rate_limiter_test
// Self-checking bench: requests go in through a queue-style driver, results
// are popped with random stalls and checked against an in-bench bucket model,
// over several capacity and refill settings written between phases.
// ----------------------------------------------------------------------------
module token_bucket_rate_limiter_test;

    typedef struct packed {
        logic [tbrl_pkg::ID_W-1:0]   bucket;
        logic [tbrl_pkg::TIME_W-1:0] now;
        logic [tbrl_pkg::CAP_W-1:0]  need;
    } t_req;

    typedef struct packed {
        logic                        allowed;
        logic [tbrl_pkg::CAP_W-1:0]  remaining;
        logic [tbrl_pkg::CAP_W-1:0]  used;
        logic [tbrl_pkg::WAIT_W-1:0] full_ms;
        logic [tbrl_pkg::WAIT_W-1:0] retry_ms;
        logic                        invalid;
    } t_verdict;

    logic                           i_clk;
    logic                           i_rst_n;
    logic                           push;
    logic                           full;
    logic [tbrl_pkg::ID_W-1:0]      i_bucket_id;
    logic [tbrl_pkg::TIME_W-1:0]    i_now_ms;
    logic [tbrl_pkg::CAP_W-1:0]     i_tokens_req;
    logic                           empty;
    logic                           pop;
    logic                           o_allowed;
    logic [tbrl_pkg::CAP_W-1:0]     o_remaining;
    logic [tbrl_pkg::CAP_W-1:0]     o_used_count;
    logic [tbrl_pkg::WAIT_W-1:0]    o_reset_after_ms;
    logic [tbrl_pkg::WAIT_W-1:0]    o_retry_after_ms;
    logic                           o_request_invalid;
    logic                           i_cfg_valid;
    logic                           o_cfg_ready;
    logic [tbrl_pkg::CFG_IDX_W-1:0] i_cfg_index;
    logic [tbrl_pkg::RATE_W-1:0]    i_cfg_data;

    token_bucket_rate_limiter i_dut (.*);

    t_req      pending_reqs[$];
    t_verdict  due_verdicts[$];
    logic [63:0] bucket_level[tbrl_pkg::NUM_BUCKETS];
    logic [tbrl_pkg::TIME_W-1:0] bucket_stamp[tbrl_pkg::NUM_BUCKETS];
    logic        bucket_live[tbrl_pkg::NUM_BUCKETS];
    logic [tbrl_pkg::CAP_W-1:0]  cap_now;
    logic [tbrl_pkg::RATE_W-1:0] rate_now;
    logic        req_fire, res_fire, no_idle, held;
    int          req_gap, res_gap, res_hold, res_count, cycles, errors;
    logic [tbrl_pkg::TIME_W-1:0] clock_ms;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    function automatic logic [63:0] ceil_wait(logic [63:0] num, logic [63:0] den);
        logic [63:0] q;
        if (num == 64'd0) return 64'd0;
        if (den == 64'd0) return 64'hFFFF_FFFF;
        q = num / den;
        if (num % den != 64'd0) q = q + 64'd1;
        return (q > 64'hFFFF_FFFF) ? 64'hFFFF_FFFF : q;
    endfunction

    function automatic t_verdict admit(t_req r);
        t_verdict v;
        logic [63:0] cap_fx, need_fx, lvl, gap, elapsed, rem, rate_fx, w;
        logic ok;
        v = '0;
        if (r.need == '0) begin
            v.invalid = 1'b1;
            return v;
        end
        rate_fx = {32'd0, rate_now};
        cap_fx = {48'd0, cap_now} << tbrl_pkg::FRAC_BITS;
        if (!bucket_live[r.bucket]) begin
            bucket_level[r.bucket] = cap_fx;
            bucket_stamp[r.bucket] = r.now;
            bucket_live[r.bucket] = 1'b1;
        end
        lvl = bucket_level[r.bucket];
        if (lvl > cap_fx) lvl = cap_fx;
        if (r.now > bucket_stamp[r.bucket]) begin
            elapsed = {16'd0, r.now - bucket_stamp[r.bucket]};
            gap = cap_fx - lvl;
            if (rate_fx != 64'd0) begin
                if (elapsed > gap / rate_fx) lvl = cap_fx;
                else lvl = lvl + elapsed * rate_fx;
            end
            bucket_stamp[r.bucket] = r.now;
        end
        need_fx = {48'd0, r.need} << tbrl_pkg::FRAC_BITS;
        ok = lvl >= need_fx;
        if (ok) lvl = lvl - need_fx;
        bucket_level[r.bucket] = lvl;
        rem = lvl >> tbrl_pkg::FRAC_BITS;
        v.allowed = ok;
        v.remaining = rem[tbrl_pkg::CAP_W-1:0];
        v.used = cap_now - rem[tbrl_pkg::CAP_W-1:0];
        w = (lvl < cap_fx) ? ceil_wait(cap_fx - lvl, rate_fx) : 64'd0;
        v.full_ms = w[tbrl_pkg::WAIT_W-1:0];
        w = ok ? 64'd0 : ceil_wait(need_fx - lvl, rate_fx);
        v.retry_ms = w[tbrl_pkg::WAIT_W-1:0];
        return v;
    endfunction

    // request driver
    always @(negedge i_clk) begin
        t_req nx;
        int   g;
        if (!i_rst_n || (push && !req_fire)) begin
        end else begin
            g = req_gap;
            if (push) begin
                void'(pending_reqs.pop_front());
                g = no_idle ? 0 : $urandom_range(0, 3);
            end
            if (g == 0 && pending_reqs.size() > 0) begin
                nx = pending_reqs[0];
                push <= 1'b1;
                i_bucket_id <= nx.bucket;
                i_now_ms <= nx.now;
                i_tokens_req <= nx.need;
            end else begin
                push <= 1'b0;
            end
            req_gap <= (g > 0) ? g - 1 : 0;
        end
    end

    // result receiver
    always @(negedge i_clk) begin
        int w;
        if (res_hold > 0) begin
            pop <= 1'b0;
            res_hold <= res_hold - 1;
        end else if (res_count == 40 && !held) begin
            pop <= 1'b0;
            held <= 1'b1;
            res_hold <= 400;
        end else if (res_fire) begin
            w = no_idle ? 0 : $urandom_range(0, 3);
            pop <= (w == 0);
            res_gap <= w;
        end else if (res_gap > 0) begin
            pop <= (res_gap == 1);
            res_gap <= res_gap - 1;
        end else begin
            pop <= 1'b1;
        end
    end

    // monitor and checker
    always @(posedge i_clk) begin
        t_verdict want, got, pred;
        req_fire <= push && !full;
        res_fire <= pop && !empty;
        cycles <= cycles + 1;
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) begin
                if (i_cfg_index == tbrl_pkg::CFG_CAPACITY)
                    cap_now = i_cfg_data[tbrl_pkg::CAP_W-1:0];
                else if (i_cfg_index == tbrl_pkg::CFG_REFILL)
                    rate_now = i_cfg_data;
            end
            if (pop && !empty) begin
                res_count <= res_count + 1;
                got = '{o_allowed, o_remaining, o_used_count, o_reset_after_ms,
                        o_retry_after_ms, o_request_invalid};
                if (due_verdicts.size() == 0) begin
                    $display("%0t: unexpected result exp none got %h", $time, got);
                    errors <= errors + 1;
                end else begin
                    want = due_verdicts.pop_front();
                    if (got !== want) begin
                        $display("%0t: mismatch exp allowed=%0d rem=%0d used=%0d %s",
                                 $time, want.allowed, want.remaining, want.used,
                                 $sformatf("full=%0d retry=%0d inv=%0d",
                                           want.full_ms, want.retry_ms, want.invalid));
                        $display("%0t:          got allowed=%0d rem=%0d used=%0d %s",
                                 $time, got.allowed, got.remaining, got.used,
                                 $sformatf("full=%0d retry=%0d inv=%0d",
                                           got.full_ms, got.retry_ms, got.invalid));
                        errors <= errors + 1;
                    end
                end
            end
            if (push && !full) begin
                pred = admit('{i_bucket_id, i_now_ms, i_tokens_req});
                due_verdicts.insert(due_verdicts.size(), pred);
            end
        end
        if (cycles > 400000) begin
            $display("token_bucket_rate_limiter_test: FAIL");
            $finish;
        end
    end

    task automatic write_reg(logic [tbrl_pkg::CFG_IDX_W-1:0] idx,
                             logic [tbrl_pkg::RATE_W-1:0] val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic drain;
        while (pending_reqs.size() > 0 || push || due_verdicts.size() > 0)
            @(posedge i_clk);
        repeat (200) @(posedge i_clk);
    endtask

    task automatic add_req(int b, logic [tbrl_pkg::TIME_W-1:0] t, int n);
        t_req r;
        r = '{b[tbrl_pkg::ID_W-1:0], t, n[tbrl_pkg::CAP_W-1:0]};
        pending_reqs.insert(pending_reqs.size(), r);
    endtask

    task automatic add_random(int count);
        int b, n, sel;
        for (int k = 0; k < count; k++) begin
            sel = $urandom_range(0, 99);
            if (sel < 5) clock_ms = clock_ms - $urandom_range(1, 50);
            else if (sel < 8) clock_ms = tbrl_pkg::TIME_W'({$urandom, $urandom});
            else clock_ms = clock_ms + $urandom_range(0, 8);
            b = ($urandom_range(0, 9) == 0) ? $urandom_range(0, tbrl_pkg::NUM_BUCKETS - 1)
                                            : $urandom_range(0, 15);
            sel = $urandom_range(0, 99);
            if (sel < 5) n = 0;
            else if (sel < 10) n = $urandom_range(0, 65535);
            else n = $urandom_range(1, cap_now / 4 + 1);
            add_req(b, clock_ms, n);
        end
    endtask

    task automatic phase(int cap, logic [tbrl_pkg::RATE_W-1:0] rate, int count,
                         logic quiet);
        write_reg(tbrl_pkg::CFG_CAPACITY, cap);
        write_reg(tbrl_pkg::CFG_REFILL, rate);
        no_idle = quiet;
        add_random(count);
        drain();
    endtask

    initial begin
        i_rst_n = 1'b0;
        push = 1'b0;
        pop = 1'b0;
        i_bucket_id = '0;
        i_now_ms = '0;
        i_tokens_req = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        req_fire = 1'b0;
        res_fire = 1'b0;
        no_idle = 1'b0;
        held = 1'b0;
        req_gap = 0;
        res_gap = 0;
        res_hold = 0;
        res_count = 0;
        cycles = 0;
        errors = 0;
        clock_ms = 48'd1000;
        cap_now = tbrl_pkg::CAP_RESET;
        rate_now = tbrl_pkg::RATE_RESET;
        for (int k = 0; k < tbrl_pkg::NUM_BUCKETS; k++) bucket_live[k] = 1'b0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed, reset settings
        add_req(5, 0, 0);
        add_req(1023, 48'hFFFF_FFFF_FFFF, 0);
        add_req(0, 0, 1);
        add_req(0, 0, 100);
        add_req(0, 10, 10);
        add_req(0, 5, 1);
        add_req(0, 200, 99);
        add_req(1023, 48'hFFFF_FFFF_FFFF, 65535);
        add_req(1023, 48'hFFFF_FFFF_FFFF, 1);
        add_req(512, 48'h5555_5555_5555, 16'h2AAA);
        add_req(341, 48'hAAAA_AAAA_AAAA, 16'h0055);
        add_req(341, 48'hAAAA_AAAA_AAAB, 16'h5555);
        add_random(250);
        drain();

        phase(1, 1, 200, 1'b0);
        phase(65535, 32'hFFFF_FFFF, 200, 1'b1);
        phase(20, 32768, 250, 1'b0);

        // zero capacity and zero refill, then capacity 50 with zero refill
        write_reg(tbrl_pkg::CFG_CAPACITY, 0);
        write_reg(tbrl_pkg::CFG_REFILL, 0);
        add_req(7, clock_ms, 1);
        add_req(7, clock_ms + 100, 3);
        add_random(20);
        drain();
        write_reg(tbrl_pkg::CFG_CAPACITY, 50);
        add_req(7, clock_ms + 200, 10);
        add_req(7, clock_ms + 900, 45);
        add_random(20);
        drain();

        phase(5000, 3000, 250, 1'b0);
        phase(100, 65536, 300, 1'b0);

        if (errors == 0) begin
            $display("token_bucket_rate_limiter_test: PASS");
        end else begin
            $display("token_bucket_rate_limiter_test: FAIL");
        end
        $finish;
    end

endmodule
